@@ rtl/core/assert_macros.svh @@
// assertion helpers, included by tremolo_triangle_lfo_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tlfo_pkg.sv @@
// ----------------------------------------------------------------------------
// tlfo_pkg
// Shared types and constants of the tremolo triangle lfo block.
// ----------------------------------------------------------------------------
package tlfo_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 17;
  localparam int MAG_W     = 17;
  localparam int PROD1_W   = MAG_W + COUNT_W;          // magnitude times count
  localparam int PROD_W    = PROD1_W + CFG_W;          // times depth
  localparam int QUO_W     = PROD_W - 16;              // product over 65536
  localparam int DIV_STEPS = QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd11025;
  localparam logic [CFG_W-1:0] DEPTH_RESET  = 16'd45875;

  localparam logic [COUNT_W-1:0] COUNT_PEAK = 17'd65536;

  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(32767);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_DEPTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ rtl/core/tremolo_triangle_lfo_top.sv @@
// ----------------------------------------------------------------------------
// tremolo_triangle_lfo_top
// Tremolo: scales each sample by count * depth / period, triangle lfo count.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------
//  in      | in_valid / in_stall   | sample_in  (s16)
//  out     | out_valid / out_stall | sample_out (s16)
//  cfg     | cfg_we                | cfg_index, cfg_data (u16)
//
//  a sample goes from transfer through the multiply states ST_MUL1 and ST_MUL2,
//  the restoring divider (a 34-bit quotient, then done) and ST_DONE, which
//  saturates and loads it; no new sample is taken until ST_DONE is left.
//  a zero period skips the divider and gives a zero result.
//  in_stall is high while a sample is being worked on; a finished result
//  waits until the output register is free, which holds it until it is taken.
//  rst is synchronous; it restores period, depth and the lfo counter.
module tremolo_triangle_lfo_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tlfo_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tlfo_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                cfg_we,
  input  logic [tlfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlfo_pkg::CFG_W-1:0]          cfg_data
);

  tlfo_pkg::state_t state, state_next;

  logic [tlfo_pkg::CFG_W-1:0]   period;
  logic [tlfo_pkg::CFG_W-1:0]   depth_q16;
  logic [tlfo_pkg::COUNT_W-1:0] lfo_count;
  logic                         count_down;

  logic [tlfo_pkg::MAG_W-1:0]   mag;
  logic                         neg;
  logic [tlfo_pkg::COUNT_W-1:0] count_snap;
  logic [tlfo_pkg::PROD1_W-1:0] prod1;
  logic [tlfo_pkg::QUO_W-1:0]   dividend;
  logic                         zero_div;

  logic                         in_xfer;
  logic                         out_free;
  logic                         div_start;
  tlfo_pkg::div_status_t        div_status;
  logic [tlfo_pkg::QUO_W-1:0]   quotient;

  logic [tlfo_pkg::MAG_W-1:0]   mag_in;
  logic [tlfo_pkg::COUNT_W-1:0] count_step;
  logic [tlfo_pkg::PROD_W-1:0]  prod_full;
  logic [tlfo_pkg::QUO_W-1:0]   q_sat;
  logic [tlfo_pkg::SAMPLE_W-1:0] result;

  assign in_stall = (state != tlfo_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= tlfo_pkg::PERIOD_RESET;
      depth_q16 <= tlfo_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      case (tlfo_pkg::cfg_reg_t'(cfg_index))
        tlfo_pkg::CFG_PERIOD: period    <= cfg_data;
        tlfo_pkg::CFG_DEPTH:  depth_q16 <= cfg_data;
        default: ;
      endcase
    end
  end

  // sign-magnitude split of the input sample
  always_comb begin
    logic [tlfo_pkg::MAG_W-1:0] ext;
    ext    = {sample_in[tlfo_pkg::SAMPLE_W-1], sample_in};
    mag_in = sample_in[tlfo_pkg::SAMPLE_W-1] ? (~ext + 1'b1) : ext;
  end

  assign count_step = count_down ? (lfo_count - 1'b1) : (lfo_count + 1'b1);

  // triangle counter steps once per transfer, after its value is captured
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_count  <= '0;
      count_down <= 1'b0;
    end else if (in_xfer) begin
      lfo_count <= count_step;
      if (count_step > {1'b0, period}) begin
        count_down <= 1'b1;
      end else if (count_step == '0) begin
        count_down <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlfo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      tlfo_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = tlfo_pkg::ST_MUL1;
        end
      end
      tlfo_pkg::ST_MUL1: state_next = tlfo_pkg::ST_MUL2;
      tlfo_pkg::ST_MUL2: begin
        if (period == '0) begin
          state_next = tlfo_pkg::ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = tlfo_pkg::ST_DIV;
        end
      end
      tlfo_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = tlfo_pkg::ST_DONE;
        end
      end
      tlfo_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tlfo_pkg::ST_IDLE;
        end
      end
      default: state_next = tlfo_pkg::ST_IDLE;
    endcase
  end

  assign prod_full = tlfo_pkg::PROD_W'(prod1) * tlfo_pkg::PROD_W'(depth_q16);

  // dividing by period << 16 is the same as dropping 16 bits first
  assign dividend = prod_full[tlfo_pkg::PROD_W-1:16];

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag        <= mag_in;
      neg        <= sample_in[tlfo_pkg::SAMPLE_W-1];
      count_snap <= lfo_count;
    end
    if (state == tlfo_pkg::ST_MUL1) begin
      prod1 <= tlfo_pkg::PROD1_W'(mag) * tlfo_pkg::PROD1_W'(count_snap);
    end
    if (state == tlfo_pkg::ST_MUL2) begin
      zero_div <= (period == '0);
    end
  end

  tlfo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (period),
    .status   (div_status),
    .quotient (quotient)
  );

  // saturate the magnitude, then restore the sign; a zero period gives zero
  always_comb begin
    if (neg) begin
      q_sat = (quotient > tlfo_pkg::NEG_LIMIT) ? tlfo_pkg::NEG_LIMIT : quotient;
    end else begin
      q_sat = (quotient > tlfo_pkg::POS_LIMIT) ? tlfo_pkg::POS_LIMIT : quotient;
    end
    if (zero_div) begin
      result = '0;
    end else if (neg) begin
      result = ~q_sat[tlfo_pkg::SAMPLE_W-1:0] + 1'b1;
    end else begin
      result = q_sat[tlfo_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tlfo_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tlfo_pkg::ST_DONE && out_free) begin
      sample_out <= result;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_range, lfo_count <= tlfo_pkg::COUNT_PEAK, "lfo count beyond peak")
  `ASSERT_CLK(a_xfer_starts, in_xfer |=> state == tlfo_pkg::ST_MUL1, "transfer did not start work")
  `ASSERT_CLK(a_out_from_done, $rose(out_valid) |-> $past(state) == tlfo_pkg::ST_DONE,
              "result shown without finished work")
  `ASSERT_CLK(a_count_hold, !in_xfer |=> $stable(lfo_count), "lfo count moved without transfer")
  `ASSERT_ALWAYS(a_div_idle, rst |=> !div_status.busy, "divider busy after reset")

endmodule

@@ rtl/core/tlfo_div.sv @@
// ----------------------------------------------------------------------------
// tlfo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlfo_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tlfo_pkg::QUO_W-1:0]  dividend,
  input  logic [tlfo_pkg::CFG_W-1:0]  divisor,
  output tlfo_pkg::div_status_t       status,
  output logic [tlfo_pkg::QUO_W-1:0]  quotient
);

  logic [tlfo_pkg::DIV_CNT_W-1:0] steps;
  logic                           busy;
  logic                           done;
  logic [tlfo_pkg::CFG_W-1:0]     rem;
  logic [tlfo_pkg::QUO_W-1:0]     quo;
  logic [tlfo_pkg::CFG_W-1:0]     div_r;

  logic [tlfo_pkg::CFG_W:0]       trial;
  logic                           fits;
  logic [tlfo_pkg::CFG_W:0]       diff;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[tlfo_pkg::QUO_W-1]};
    fits  = (trial >= {1'b0, div_r});
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= tlfo_pkg::DIV_CNT_W'(tlfo_pkg::DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == tlfo_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend;
      div_r <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits in CFG_W bits
      rem <= fits ? diff[tlfo_pkg::CFG_W-1:0] : trial[tlfo_pkg::CFG_W-1:0];
      quo <= {quo[tlfo_pkg::QUO_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

@@ dv/tremolo_triangle_lfo_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tremolo_triangle_lfo_top_tb
// Sends audio samples through the tremolo with random gaps on both sides and
// checks every output sample against a local triangle lfo and gain predictor.
// Period and depth change between runs of samples, the extremes included.
// ----------------------------------------------------------------------------
module tremolo_triangle_lfo_top_tb;

  localparam int TOTAL_SAMPLES = 1350;
  localparam int CALM_SAMPLES  = 150;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [tlfo_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [tlfo_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 cfg_we = 1'b0;
  logic [tlfo_pkg::CFG_IDX_W-1:0]       cfg_index = tlfo_pkg::CFG_PERIOD;
  logic [tlfo_pkg::CFG_W-1:0]           cfg_data = '0;

  tremolo_triangle_lfo_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: gain settings and the triangle position
  logic [tlfo_pkg::CFG_W-1:0]   gain_period = tlfo_pkg::PERIOD_RESET;
  logic [tlfo_pkg::CFG_W-1:0]   gain_depth  = tlfo_pkg::DEPTH_RESET;
  logic [tlfo_pkg::COUNT_W-1:0] tri_pos     = '0;
  logic                         tri_falling = 1'b0;

  logic signed [tlfo_pkg::SAMPLE_W-1:0] samples_to_send[$];
  logic signed [tlfo_pkg::SAMPLE_W-1:0] samples_due[$];

  int  n_sent = 0;
  int  n_checked = 0;
  int  n_settings = 0;
  int  fault_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  logic calm = 1'b0;
  logic hold_long = 1'b0;

  // sample times pos*depth/(65536*period), truncated toward zero, saturated
  function automatic logic signed [tlfo_pkg::SAMPLE_W-1:0] tremolo_sample(
    logic signed [tlfo_pkg::SAMPLE_W-1:0] s);
    logic [16:0] mag;
    logic [63:0] prod;
    logic [63:0] quo;
    if (gain_period == '0)
      return '0;
    mag  = s[15] ? 17'(17'h10000 - {1'b0, s}) : {1'b0, s};
    prod = 64'(mag) * 64'(tri_pos) * 64'(gain_depth);
    quo  = prod / (64'(gain_period) << 16);
    if (s[15]) begin
      if (quo > 64'd32768)
        quo = 64'd32768;
      return tlfo_pkg::SAMPLE_W'(64'd0 - quo);
    end
    if (quo > 64'd32767)
      quo = 64'd32767;
    return tlfo_pkg::SAMPLE_W'(quo);
  endfunction

  function automatic void lfo_advance();
    if (tri_falling)
      tri_pos = tri_pos - 1'b1;
    else
      tri_pos = tri_pos + 1'b1;
    if (tri_pos > tlfo_pkg::COUNT_W'(gain_period))
      tri_falling = 1'b1;
    else if (tri_pos == '0)
      tri_falling = 1'b0;
  endfunction

  function automatic logic signed [tlfo_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return tlfo_pkg::SAMPLE_W'($signed($urandom_range(0, 15)) - 8);
      default: return tlfo_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic note_fault(string what, logic signed [tlfo_pkg::SAMPLE_W-1:0] want,
                            logic signed [tlfo_pkg::SAMPLE_W-1:0] got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic write_reg(tlfo_pkg::cfg_reg_t idx, logic [tlfo_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tlfo_pkg::CFG_PERIOD)
      gain_period = val;
    else
      gain_depth = val;
  endtask

  task automatic wait_drained();
    while (samples_to_send.size() > 0 || samples_due.size() > 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  // sender: offers queued samples, predicts each one on its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        samples_due.push_back(tremolo_sample(sample_in));
        lfo_advance();
        void'(samples_to_send.pop_front());
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 8) begin
          gap_left = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          in_valid  <= 1'b1;
          sample_in <= samples_to_send[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each output transfer, stalls in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (samples_due.size() == 0)
          note_fault("output with nothing pending", '0, sample_out);
        else if (sample_out !== samples_due[0])
          note_fault("sample_out mismatch", samples_due[0], sample_out);
        if (samples_due.size() > 0)
          void'(samples_due.pop_front());
        n_checked++;
      end
      if (hold_long) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    while (n_sent < 300 || samples_to_send.size() < 10)
      @(posedge clk);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tremolo_triangle_lfo_top_tb failed");
    $finish;
  end

  initial begin
    int queued;
    int n;
    int mode;
    logic [tlfo_pkg::CFG_W-1:0] per;
    logic [tlfo_pkg::CFG_W-1:0] dep;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings, lfo rising from zero
    n_settings++;
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'sh0000);
    samples_to_send.push_back(16'shffff);
    samples_to_send.push_back(16'sh0001);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'sh5555);
    samples_to_send.push_back(16'shaaaa);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh8001);
    samples_to_send.push_back(16'sh8000);
    wait_drained();

    // tiny period and full depth: gain above one, saturation both ways
    write_reg(tlfo_pkg::CFG_PERIOD, 16'd1);
    write_reg(tlfo_pkg::CFG_DEPTH, 16'hffff);
    n_settings++;
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'shffff);
    samples_to_send.push_back(16'sh0001);
    samples_to_send.push_back(16'sh0000);
    samples_to_send.push_back(16'sh7fff);
    wait_drained();

    // zero period gives silence while the lfo keeps stepping
    write_reg(tlfo_pkg::CFG_PERIOD, 16'd0);
    n_settings++;
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh8000);
    samples_to_send.push_back(16'sh1234);
    samples_to_send.push_back(16'shffff);
    samples_to_send.push_back(16'sh7fff);
    wait_drained();

    queued = 25;
    mode = 0;
    while (queued < TOTAL_SAMPLES - CALM_SAMPLES) begin
      case (mode % 5)
        0: per = tlfo_pkg::CFG_W'($urandom_range(1, 64));
        1: per = tlfo_pkg::CFG_W'($urandom_range(65, 2000));
        2: begin
          case ($urandom_range(0, 2))
            0: per = 16'hffff;
            1: per = 16'd0;
            default: per = 16'd1;
          endcase
        end
        // drop the period under a risen lfo
        3: per = tlfo_pkg::CFG_W'($urandom_range(0, 4));
        default: per = tlfo_pkg::CFG_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: dep = 16'hffff;
        1: dep = 16'd0;
        default: dep = tlfo_pkg::CFG_W'($urandom);
      endcase
      write_reg(tlfo_pkg::CFG_PERIOD, per);
      if ($urandom_range(0, 3) != 0)
        write_reg(tlfo_pkg::CFG_DEPTH, dep);
      n_settings++;
      n = $urandom_range(60, 160);
      if (n > TOTAL_SAMPLES - CALM_SAMPLES - queued)
        n = TOTAL_SAMPLES - CALM_SAMPLES - queued;
      repeat (n) samples_to_send.push_back(pick_sample());
      queued += n;
      mode++;
      wait_drained();
    end

    // closing stretch at full rate on both sides
    write_reg(tlfo_pkg::CFG_PERIOD, tlfo_pkg::CFG_W'($urandom_range(20, 200)));
    write_reg(tlfo_pkg::CFG_DEPTH, tlfo_pkg::CFG_W'($urandom));
    n_settings++;
    calm <= 1'b1;
    repeat (CALM_SAMPLES) samples_to_send.push_back(pick_sample());
    wait_drained();
    repeat (50) @(posedge clk);

    fault_count += samples_due.size();
    $display("%0d samples sent, %0d outputs checked over %0d period/depth settings",
             n_sent, n_checked, n_settings);
    $display("settings included zero, unit and full period and the depth extremes");
    if (fault_count == 0)
      $display("tremolo_triangle_lfo_top_tb passed");
    else
      $display("tremolo_triangle_lfo_top_tb failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tlfo_pkg.sv
rtl/core/tlfo_div.sv
rtl/core/tremolo_triangle_lfo_top.sv
dv/tremolo_triangle_lfo_top_tb.sv
